### design/plm_pkg.sv
// Shared types and constants for the piecewise linear map unit.
// No dependencies; used by plm_div, plm_ctrl, plm_dp and the top level.
`timescale 1ns / 1ps

package plm_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned WordW     = 64;
  localparam int unsigned CountW    = 3;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned MinPoints = 2;
  localparam int unsigned DivSteps  = 32;
  localparam int unsigned DivCntW   = 5;

  // Register indices on the configuration channel
  localparam logic [CfgIdxW-1:0] CfgIdxCount     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxFirstWord = 3'd1;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StScan = 5'b00010,
    StMul  = 5'b00100,
    StDiv  = 5'b01000,
    StDone = 5'b10000
  } state_e;

  typedef struct packed {
    logic load;      // capture sample, clear match record
    logic scan;      // evaluate one breakpoint
    logic first;     // breakpoint 0: no segment yet
    logic mul;       // form product, load divider
    logic div_step;  // one quotient bit
    logic out_load;  // register result
  } cmd_t;

  typedef struct packed {
    logic need_div;  // a segment of non-zero width matched
  } status_t;

endpackage

### design/plm_div.sv
// Restoring divider, one quotient bit per cycle while step_i is high, 64-bit dividend by 32-bit divisor.
// Requires the upper dividend half below the divisor; depends on plm_pkg.
`timescale 1ns / 1ps

module plm_div (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  logic                                step_i,
  input  logic [plm_pkg::WordW-1:0]           dividend_i,
  input  logic [plm_pkg::DataW-1:0]           divisor_i,
  output logic [plm_pkg::DataW-1:0]           quotient_o
);

  logic [plm_pkg::DataW-1:0] rem_q, rem_d;
  logic [plm_pkg::DataW-1:0] low_q, low_d;
  logic [plm_pkg::DataW-1:0] dvs_q;
  logic [plm_pkg::DataW:0]   shifted;
  logic [plm_pkg::DataW:0]   diff;
  logic                      ge;

  always_comb begin
    shifted = {rem_q, low_q[plm_pkg::DataW-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = (shifted >= {1'b0, dvs_q});
    rem_d   = ge ? diff[plm_pkg::DataW-1:0] : shifted[plm_pkg::DataW-1:0];
    low_d   = {low_q[plm_pkg::DataW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= dividend_i[plm_pkg::WordW-1:plm_pkg::DataW];
      low_q <= dividend_i[plm_pkg::DataW-1:0];
      dvs_q <= divisor_i;
    end else if (step_i) begin
      rem_q <= rem_d;
      low_q <= low_d;
    end
  end

  assign quotient_o = low_q;

endmodule

### design/plm_ctrl.sv
// Sequencer for the piecewise linear map: scan, multiply, divide, deliver.
// Drives plm_dp through plm_pkg::cmd_t; depends on plm_pkg.
`timescale 1ns / 1ps

module plm_ctrl #(
  parameter int unsigned MAX_POINTS = 7
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [plm_pkg::CountW-1:0]          n_eff_i,
  input  plm_pkg::status_t                    status_i,
  output plm_pkg::cmd_t                       cmd_o,
  output logic [$clog2(MAX_POINTS)-1:0]       rd_idx_o,
  output logic                                busy_o,
  output logic                                valid_o
);

  localparam int unsigned IdxW = $clog2(MAX_POINTS);

  plm_pkg::state_e                state_q, state_d;
  logic [IdxW-1:0]                k_q, k_d;
  logic [plm_pkg::DivCntW-1:0]    cnt_q, cnt_d;
  logic                           valid_q;
  logic                           last_pt;

  assign last_pt = ({{(plm_pkg::CountW-IdxW){1'b0}}, k_q} == (n_eff_i - 3'd1));

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      plm_pkg::StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          k_d        = '0;
          if (n_eff_i >= plm_pkg::CountW'(plm_pkg::MinPoints)) begin
            state_d = plm_pkg::StScan;
          end else begin
            state_d = plm_pkg::StDone;
          end
        end
      end
      plm_pkg::StScan: begin
        cmd_o.scan  = 1'b1;
        cmd_o.first = (k_q == '0);
        if (last_pt) begin
          state_d = plm_pkg::StMul;
        end else begin
          k_d = k_q + IdxW'(1);
        end
      end
      plm_pkg::StMul: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = status_i.need_div ? plm_pkg::StDiv : plm_pkg::StDone;
      end
      plm_pkg::StDiv: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == plm_pkg::DivCntW'(plm_pkg::DivSteps - 1)) begin
          state_d = plm_pkg::StDone;
        end else begin
          cnt_d = cnt_q + plm_pkg::DivCntW'(1);
        end
      end
      plm_pkg::StDone: begin
        cmd_o.out_load = 1'b1;
        state_d        = plm_pkg::StIdle;
      end
      default: begin
        state_d = plm_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plm_pkg::StIdle;
      k_q     <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      valid_q <= cmd_o.out_load;
    end
  end

  assign rd_idx_o = k_q;
  assign busy_o   = (state_q != plm_pkg::StIdle);
  assign valid_o  = valid_q;

endmodule

### design/plm_dp.sv
// Datapath: breakpoint registers, segment match, multiplier, divider and result.
// Instantiates plm_div; depends on plm_pkg.
`timescale 1ns / 1ps

module plm_dp #(
  parameter int unsigned MAX_POINTS = 7
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [plm_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [plm_pkg::WordW-1:0]           cfg_data_i,
  input  logic signed [plm_pkg::DataW-1:0]    sample_i,
  input  plm_pkg::cmd_t                       cmd_i,
  input  logic [$clog2(MAX_POINTS)-1:0]       rd_idx_i,
  output logic [plm_pkg::CountW-1:0]          n_eff_o,
  output plm_pkg::status_t                    status_o,
  output logic signed [plm_pkg::DataW-1:0]    mapped_o,
  output logic                                segment_hit_o
);

  localparam int unsigned IdxW = $clog2(MAX_POINTS);
  localparam int unsigned DW   = plm_pkg::DataW;

  logic [plm_pkg::CountW-1:0]   count_q;
  logic [plm_pkg::WordW-1:0]    word_q [MAX_POINTS];
  logic [plm_pkg::CfgIdxW-1:0]  widx;
  logic                         wsel;

  logic signed [DW-1:0] x_q, prev_in_q, prev_out_q, o0_q;
  logic [DW-1:0]        dx_q, width_q, mag_q;
  logic                 neg_q, zero_q, hit_q;
  logic signed [DW-1:0] mapped_q;
  logic                 seg_hit_q;

  logic [plm_pkg::WordW-1:0] cur_word;
  logic signed [DW-1:0]      cur_in, cur_out;
  logic                      match;
  logic signed [DW:0]        dout;
  logic [DW:0]               dout_abs;
  logic [plm_pkg::WordW-1:0] prod;
  logic [DW-1:0]             quot;
  logic signed [DW-1:0]      interp;

  // Configuration writes
  assign widx = cfg_index_i - plm_pkg::CfgIdxFirstWord;
  assign wsel = (cfg_index_i != plm_pkg::CfgIdxCount) &&
                ({1'b0, widx} < (plm_pkg::CfgIdxW + 1)'(MAX_POINTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < int'(MAX_POINTS); i++) begin
        word_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == plm_pkg::CfgIdxCount) begin
        count_q <= cfg_data_i[plm_pkg::CountW-1:0];
      end else if (wsel) begin
        word_q[widx[IdxW-1:0]] <= cfg_data_i;
      end
    end
  end

  assign n_eff_o = (count_q > plm_pkg::CountW'(MAX_POINTS)) ?
                   plm_pkg::CountW'(MAX_POINTS) : count_q;

  // Segment evaluation against the previous breakpoint
  assign cur_word = word_q[rd_idx_i];
  assign cur_in   = cur_word[plm_pkg::WordW-1:DW];
  assign cur_out  = cur_word[DW-1:0];
  assign match    = (x_q >= prev_in_q) && (x_q <= cur_in);
  assign dout     = {cur_out[DW-1], cur_out} - {prev_out_q[DW-1], prev_out_q};
  assign dout_abs = dout[DW] ? (-dout) : dout;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.load) begin
      hit_q <= 1'b0;
    end else if (cmd_i.scan && !cmd_i.first && match) begin
      hit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= sample_i;
    end
    if (cmd_i.scan) begin
      prev_in_q  <= cur_in;
      prev_out_q <= cur_out;
      // the last matching segment wins
      if (!cmd_i.first && match) begin
        o0_q    <= prev_out_q;
        dx_q    <= x_q - prev_in_q;
        width_q <= cur_in - prev_in_q;
        zero_q  <= (cur_in == prev_in_q);
        neg_q   <= dout[DW];
        mag_q   <= dout_abs[DW-1:0];
      end
    end
  end

  assign status_o.need_div = hit_q && !zero_q;

  // dx * |dout| / width; dx never exceeds width, so the quotient fits 32 bits
  assign prod = dx_q * mag_q;

  plm_div u_div (
    .clk_i      (clk_i),
    .load_i     (cmd_i.mul),
    .step_i     (cmd_i.div_step),
    .dividend_i (prod),
    .divisor_i  (width_q),
    .quotient_o (quot)
  );

  assign interp = neg_q ? (o0_q - quot) : (o0_q + quot);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      seg_hit_q <= hit_q;
      if (!hit_q) begin
        mapped_q <= x_q;
      end else if (zero_q) begin
        mapped_q <= o0_q;
      end else begin
        mapped_q <= interp;
      end
    end
  end

  assign mapped_o      = mapped_q;
  assign segment_hit_o = seg_hit_q;

endmodule

### design/piecewise_linear_map_unit.sv
// Top level of the piecewise linear map unit.
// Instantiates plm_ctrl and plm_dp; depends on plm_pkg.
`timescale 1ns / 1ps

// Maps a signed Q16.16 sample through a breakpoint table of up to MAX_POINTS
// points: the last segment whose input span holds the sample interpolates the
// output, otherwise the sample passes through and segment_hit_o stays low.
//
// Request channel: a request is taken on a clock edge with start high and
// busy low; sample_i is captured there. busy stays high until the work ends.
// Result channel: result_valid_o pulses for one cycle with mapped_o and
// segment_hit_o; the receiver cannot stall it, so take it in that cycle.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// index 0 is the point count, 1 to 7 the point words. cfg_ready_o is always
// high. Write only while the unit is idle.
//
// From the accepting edge the unit scans the table (one breakpoint read per
// cycle), forms the product, runs the one-bit-per-cycle divider and then
// registers the result together with the strobe. A match on a zero-width
// segment or a miss skips the divider, and a table under two points skips
// both the scan and the divider.
// The next request may be taken in the cycle the strobe is shown.
// Reset clears the sequencer, the point count and all point words.

module piecewise_linear_map_unit #(
  parameter int unsigned MAX_POINTS = 7
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [plm_pkg::DataW-1:0]    sample_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [plm_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [plm_pkg::WordW-1:0]           cfg_data_i,
  output logic                                result_valid_o,
  output logic signed [plm_pkg::DataW-1:0]    mapped_o,
  output logic                                segment_hit_o
);

  plm_pkg::cmd_t                    cmd;
  plm_pkg::status_t                 status;
  logic [$clog2(MAX_POINTS)-1:0]    rd_idx;
  logic [plm_pkg::CountW-1:0]       n_eff;

  // Register writes are always accepted
  assign cfg_ready_o = 1'b1;

  plm_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .n_eff_i  (n_eff),
    .status_i (status),
    .cmd_o    (cmd),
    .rd_idx_o (rd_idx),
    .busy_o   (busy),
    .valid_o  (result_valid_o)
  );

  plm_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .sample_i      (sample_i),
    .cmd_i         (cmd),
    .rd_idx_i      (rd_idx),
    .n_eff_o       (n_eff),
    .status_o      (status),
    .mapped_o      (mapped_o),
    .segment_hit_o (segment_hit_o)
  );

endmodule
